// ===== src/tcp_pkg.sv =====
// tcp_pkg: types, character codes and keyword tables for the text command line parser.
// No dependencies; the matcher, the scaler, the top and the bench import it.
`timescale 1ns / 1ps

package tcp_pkg;

    // Line match phases
    typedef enum logic [3:0] {
        PH_START,
        PH_E,
        PH_D,
        PH_S,
        PH_STOP,
        PH_SETP,
        PH_T,
        PH_EN_OK,
        PH_DIS_OK,
        PH_REJECT,
        PH_SET_LEAD,
        PH_SET_INT,
        PH_SET_FRAC,
        PH_TURN_LEAD,
        PH_TURN_INT
    } phase_t;

    typedef enum logic [1:0] {
        KIND_ENABLE,
        KIND_DISABLE,
        KIND_SETPOINT,
        KIND_TURN
    } cmd_kind_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_T     = 8'h54;

    localparam logic [31:0] MAG_CAP = 32'h8000_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

    // Matcher result handed to the scaling logic
    typedef struct packed {
        logic        emit;
        cmd_kind_t   kind;
        logic        negative;
        logic [31:0] acc;
        logic [1:0]  frac;
    } hit_t;

    typedef struct packed {
        cmd_kind_t          cmd_kind;
        logic signed [31:0] pitch_centideg;
        logic signed [31:0] turn_rate_hz;
    } cmd_t;

    // Keyword length for a keyword phase
    function automatic logic [3:0] kw_len(phase_t ph);
        logic [3:0] len;
        unique case (ph)
            PH_E:    len = 4'd6;
            PH_D:    len = 4'd7;
            PH_STOP: len = 4'd4;
            PH_SETP: len = 4'd9;
            PH_T:    len = 4'd5;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

    // Expected character at a line position for a keyword phase
    function automatic logic [7:0] kw_char(phase_t ph, logic [3:0] pos);
        logic [71:0] w;
        logic [71:0] w_sh;
        unique case (ph)
            PH_E:    w = {"ENABLE", 24'h0};
            PH_D:    w = {"DISABLE", 16'h0};
            PH_STOP: w = {"STOP", 40'h0};
            PH_SETP: w = "SETPOINT ";
            PH_T:    w = {"TURN ", 32'h0};
            default: w = 72'h0;
        endcase
        w_sh = w << {pos, 3'b000};
        return w_sh[71:64];
    endfunction

    // Phase reached once the keyword is complete
    function automatic phase_t kw_done(phase_t ph);
        phase_t nx;
        unique case (ph)
            PH_E:    nx = PH_EN_OK;
            PH_D:    nx = PH_DIS_OK;
            PH_STOP: nx = PH_DIS_OK;
            PH_SETP: nx = PH_SET_LEAD;
            PH_T:    nx = PH_TURN_LEAD;
            default: nx = PH_REJECT;
        endcase
        return nx;
    endfunction

    // acc * 10 + d, capped at 2^31
    function automatic logic [31:0] add_digit(logic [31:0] acc, logic [3:0] d);
        logic [35:0] v;
        v = (36'(acc) << 3) + (36'(acc) << 1) + 36'(d);
        return (v > 36'(MAG_CAP)) ? MAG_CAP : v[31:0];
    endfunction

endpackage

// ===== src/tcp_ifs.sv =====
// Valid/ready channel interfaces of the parser: byte input and command output.
// Depends on nothing.
`timescale 1ns / 1ps

interface tcp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tcp_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd_kind;
    logic signed [31:0] pitch_centideg;
    logic signed [31:0] turn_rate_hz;

    modport source (output valid, output cmd_kind, output pitch_centideg,
                    output turn_rate_hz, input ready);
    modport sink   (input valid, input cmd_kind, input pitch_centideg,
                    input turn_rate_hz, output ready);
endinterface

// ===== src/tcp_matcher.sv =====
// tcp_matcher: per-line match state and one-byte step of the keyword/number matcher.
// Depends on tcp_pkg.
`timescale 1ns / 1ps

module tcp_matcher #(
    parameter int MAX_LINE_CHARS = 63
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    rx_byte,
    output tcp_pkg::hit_t hit
);
    import tcp_pkg::*;

    localparam int CW = $clog2(MAX_LINE_CHARS + 1);

    phase_t        phase_reg, phase_next;
    logic [CW-1:0] count_reg, count_next;
    logic          neg_reg, neg_next;
    logic [31:0]   acc_reg, acc_next;
    logic [1:0]    frac_reg, frac_next;
    logic          ended_reg, ended_next;

    logic   is_digit;
    logic   is_blank;
    logic   is_set;
    phase_t lead_ph;
    phase_t int_ph;
    logic [3:0] klen;

    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign is_blank = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) ||
                      (rx_byte == CH_VT) || (rx_byte == CH_FF);
    assign is_set   = (phase_reg == PH_SET_LEAD) || (phase_reg == PH_SET_INT) ||
                      (phase_reg == PH_SET_FRAC);
    assign lead_ph  = is_set ? PH_SET_LEAD : PH_TURN_LEAD;
    assign int_ph   = is_set ? PH_SET_INT : PH_TURN_INT;
    assign klen     = kw_len(phase_reg);

    // Result seen at end of line
    always_comb
    begin
        hit          = '0;
        hit.negative = neg_reg;
        hit.acc      = acc_reg;
        hit.frac     = frac_reg;
        hit.kind     = KIND_ENABLE;
        if (step && rx_byte == CH_LF && count_reg != '0)
        begin
            unique case (phase_reg)
                PH_EN_OK:
                begin
                    hit.emit = 1'b1;
                    hit.kind = KIND_ENABLE;
                end
                PH_DIS_OK:
                begin
                    hit.emit = 1'b1;
                    hit.kind = KIND_DISABLE;
                end
                PH_SET_LEAD, PH_SET_INT, PH_SET_FRAC:
                begin
                    hit.emit = 1'b1;
                    hit.kind = KIND_SETPOINT;
                end
                PH_TURN_LEAD, PH_TURN_INT:
                begin
                    hit.emit = 1'b1;
                    hit.kind = KIND_TURN;
                end
                default:
                begin
                    hit.emit = 1'b0;
                end
            endcase
        end
    end

    // Next match state
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        frac_next  = frac_reg;
        ended_next = ended_reg;
        priority if (!step || rx_byte == CH_CR)
        begin
            // carriage returns are dropped
        end
        else if (rx_byte == CH_LF || count_reg >= CW'(MAX_LINE_CHARS))
        begin
            // end of line, or overlong line: restart empty
            phase_next = PH_START;
            count_next = '0;
            neg_next   = 1'b0;
            acc_next   = '0;
            frac_next  = '0;
            ended_next = 1'b0;
        end
        else
        begin
            count_next = count_reg + 1'b1;
            priority if (ended_reg)
            begin
                // rest of line ignored
            end
            else if (rx_byte == CH_NUL)
            begin
                ended_next = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_START:
                    begin
                        priority if (rx_byte == CH_E)      phase_next = PH_E;
                        else if (rx_byte == CH_D)          phase_next = PH_D;
                        else if (rx_byte == CH_S)          phase_next = PH_S;
                        else if (rx_byte == CH_T)          phase_next = PH_T;
                        else                               phase_next = PH_REJECT;
                    end
                    PH_S:
                    begin
                        priority if (rx_byte == CH_T)      phase_next = PH_STOP;
                        else if (rx_byte == CH_E)          phase_next = PH_SETP;
                        else                               phase_next = PH_REJECT;
                    end
                    PH_E, PH_D, PH_STOP, PH_SETP, PH_T:
                    begin
                        if (count_reg < CW'(klen) && rx_byte == kw_char(phase_reg, count_reg[3:0]))
                        begin
                            if (count_reg == CW'(klen - 4'd1))
                                phase_next = kw_done(phase_reg);
                        end
                        else
                        begin
                            phase_next = PH_REJECT;
                        end
                    end
                    PH_SET_FRAC:
                    begin
                        if (is_digit)
                        begin
                            if (frac_reg < 2'd2)
                            begin
                                acc_next  = add_digit(acc_reg, rx_byte[3:0]);
                                frac_next = frac_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            ended_next = 1'b1;
                        end
                    end
                    PH_SET_LEAD, PH_SET_INT, PH_TURN_LEAD, PH_TURN_INT:
                    begin
                        priority if (is_digit)
                        begin
                            acc_next   = add_digit(acc_reg, rx_byte[3:0]);
                            phase_next = int_ph;
                        end
                        else if (is_set && rx_byte == CH_DOT)
                        begin
                            phase_next = PH_SET_FRAC;
                        end
                        else if (phase_reg == lead_ph && is_blank)
                        begin
                            // leading blank skipped
                        end
                        else if (phase_reg == lead_ph &&
                                 (rx_byte == CH_PLUS || rx_byte == CH_MINUS))
                        begin
                            neg_next   = (rx_byte == CH_MINUS);
                            phase_next = int_ph;
                        end
                        else
                        begin
                            ended_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_REJECT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            count_reg <= '0;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            frac_reg  <= '0;
            ended_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            frac_reg  <= frac_next;
            ended_reg <= ended_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_LINE_CHARS))
        else $error("line count beyond limit");

    a_lf_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && rx_byte == CH_LF |=> count_reg == '0 && phase_reg == PH_START && !ended_reg)
        else $error("newline did not restart the line");

    a_acc_capped: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg <= MAG_CAP)
        else $error("accumulator above cap");
`endif

endmodule

// ===== src/tcp_scale.sv =====
// tcp_scale: turns a matched number into the signed, saturated command fields.
// Depends on tcp_pkg.
`timescale 1ns / 1ps

module tcp_scale (
    input  tcp_pkg::hit_t hit,
    output tcp_pkg::cmd_t cmd
);
    import tcp_pkg::*;

    logic [6:0]  mul;
    logic [38:0] prod;
    logic [31:0] mag;
    logic [31:0] sval;

    // setpoint is scaled to hundredths by the missing fraction digits
    always_comb
    begin
        if (hit.kind == KIND_SETPOINT)
        begin
            unique case (hit.frac)
                2'd0:    mul = 7'd100;
                2'd1:    mul = 7'd10;
                default: mul = 7'd1;
            endcase
        end
        else
        begin
            mul = 7'd1;
        end
    end

    assign prod = 39'(hit.acc) * 39'(mul);

    always_comb
    begin
        if (hit.negative)
        begin
            mag  = (prod >= 39'(MAG_CAP)) ? MAG_CAP : prod[31:0];
            sval = ~mag + 32'd1;
        end
        else
        begin
            mag  = (prod > 39'(POS_MAX)) ? POS_MAX : prod[31:0];
            sval = mag;
        end
    end

    always_comb
    begin
        cmd.cmd_kind       = hit.kind;
        cmd.pitch_centideg = (hit.kind == KIND_SETPOINT) ? sval : 32'sd0;
        cmd.turn_rate_hz   = (hit.kind == KIND_TURN) ? sval : 32'sd0;
    end

endmodule

// ===== src/text_command_line_parser_top.sv =====
// A held byte is matched when the matcher steps on it, which also loads any command it ends.
// Throughput: one byte per cycle; the only limit is the command output register,
// which holds the matcher while a finished command is not taken.
// One more byte is taken into the input register while the output stalls.
// Reset (rst_n low, asynchronous) clears the line state and both valid flags;
// the block starts at the beginning of an empty line.
`timescale 1ns / 1ps

module text_command_line_parser_top #(
    parameter int MAX_LINE_CHARS = 63
) (
    input  logic      clk,
    input  logic      rst_n,
    tcp_byte_if.sink  rx,
    tcp_cmd_if.source cmd
);
    import tcp_pkg::*;

    // Input register: one received byte waiting for the matcher
    logic       byte_valid_reg;
    logic [7:0] byte_reg;

    // Output register: one finished command waiting for the sink
    logic out_valid_reg;
    cmd_t cmd_reg;

    logic fire;      // matcher consumes the held byte this cycle
    hit_t hit;
    cmd_t cmd_new;

    // The held byte advances when the output slot is free or drains now.
    assign fire     = byte_valid_reg && (!out_valid_reg || cmd.ready);
    assign rx.ready = !byte_valid_reg || fire;

    tcp_matcher #(
        .MAX_LINE_CHARS (MAX_LINE_CHARS)
    ) u_matcher (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (fire),
        .rx_byte (byte_reg),
        .hit     (hit)
    );

    tcp_scale u_scale (
        .hit (hit),
        .cmd (cmd_new)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (rx.valid && rx.ready)
                byte_valid_reg <= 1'b1;
            else if (fire)
                byte_valid_reg <= 1'b0;

            if (fire && hit.emit)
                out_valid_reg <= 1'b1;
            else if (cmd.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
            byte_reg <= rx.rx_byte;
        if (fire && hit.emit)
            cmd_reg <= cmd_new;
    end

    assign cmd.valid          = out_valid_reg;
    assign cmd.cmd_kind       = cmd_reg.cmd_kind;
    assign cmd.pitch_centideg = cmd_reg.pitch_centideg;
    assign cmd.turn_rate_hz   = cmd_reg.turn_rate_hz;

`ifndef NO_ASSERTIONS
    a_accept_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rx.valid && rx.ready |=> byte_valid_reg)
        else $error("accepted byte not held");

    a_hit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        fire && hit.emit |=> cmd.valid)
        else $error("matched command not presented");

    a_no_step_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !cmd.ready |-> !fire)
        else $error("matcher stepped while command stalled");
`endif

endmodule

// ===== tb/sv/tb_text_command_line_parser_top.sv =====
// tb_text_command_line_parser_top: self-checking bench for the text command line parser.
// Needs tcp_pkg, the byte and command channel interfaces, and text_command_line_parser_top.
`timescale 1ns / 1ps

module tb_text_command_line_parser_top;
    import tcp_pkg::*;

    localparam int LINE_LIMIT    = 63;
    localparam int BYTE_TARGET   = 1600;    // stimulus stops once this many bytes are queued
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_AFTER    = 600;     // bytes taken before the long output hold-off
    localparam int HOLD_CYCLES   = 400;
    localparam int TAIL_BYTES    = 150;     // no idling once this few bytes remain
    localparam int SETTLE_CYCLES = 10;

    logic clk = 1'b0;
    logic rst_n;

    tcp_byte_if byte_ch ();
    tcp_cmd_if  cmd_ch ();

    text_command_line_parser_top #(
        .MAX_LINE_CHARS (LINE_LIMIT)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (byte_ch),
        .cmd   (cmd_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Line tracker: follows the parser's line state byte by byte and
    // queues the command that each finished line should produce.
    // ------------------------------------------------------------------
    phase_t      line_phase;
    int unsigned line_len;      // characters held in the current line
    bit          num_neg;
    logic [33:0] num_mag;       // magnitude, held at 2^31 once it gets there
    int unsigned frac_taken;    // fraction digits folded in, 0..2
    bit          num_done;      // rest of line is ignored
    cmd_t        expected_cmds[$];

    string keywords[5] = '{"ENABLE", "DISABLE", "STOP", "SETPOINT ", "TURN "};

    task automatic clear_line_state();
        line_phase = PH_START;
        line_len   = 0;
        num_neg    = 1'b0;
        num_mag    = '0;
        frac_taken = 0;
        num_done   = 1'b0;
    endtask

    // mag * 10 + d, held at 2^31
    function automatic logic [33:0] shift_in_digit(logic [33:0] mag, logic [3:0] d);
        logic [39:0] v;
        v = 40'(mag) * 40'd10 + 40'(d);
        return (v > 40'(MAG_CAP)) ? 34'(MAG_CAP) : v[33:0];
    endfunction

    function automatic logic signed [31:0] signed_value(bit neg, logic [33:0] mag);
        logic [33:0] m;
        if (neg)
        begin
            m = (mag > 34'(MAG_CAP)) ? 34'(MAG_CAP) : mag;
            return 32'd0 - m[31:0];     // 2^31 wraps to the most negative value
        end
        m = (mag > 34'(POS_MAX)) ? 34'(POS_MAX) : mag;
        return m[31:0];
    endfunction

    task automatic take_keyword_char(input logic [7:0] c, input int unsigned pos);
        string  word;
        phase_t done_ph;
        case (line_phase)
            PH_E:
            begin
                word    = "ENABLE";
                done_ph = PH_EN_OK;
            end
            PH_D:
            begin
                word    = "DISABLE";
                done_ph = PH_DIS_OK;
            end
            PH_STOP:
            begin
                word    = "STOP";
                done_ph = PH_DIS_OK;
            end
            PH_SETP:
            begin
                word    = "SETPOINT ";
                done_ph = PH_SET_LEAD;
            end
            default:
            begin
                word    = "TURN ";
                done_ph = PH_TURN_LEAD;
            end
        endcase
        // position is counted from the start of the line, not of the keyword tail
        if (pos < word.len() && c == word[pos])
        begin
            if (pos + 1 == word.len())
                line_phase = done_ph;
        end
        else
        begin
            line_phase = PH_REJECT;
        end
    endtask

    task automatic take_number_char(input logic [7:0] c, input bit with_frac);
        bit     is_digit;
        phase_t lead_ph;
        phase_t int_ph;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        lead_ph  = with_frac ? PH_SET_LEAD : PH_TURN_LEAD;
        int_ph   = with_frac ? PH_SET_INT : PH_TURN_INT;
        if (line_phase == PH_SET_FRAC)
        begin
            // third and later fraction digits are dropped (truncation)
            if (!is_digit)
                num_done = 1'b1;
            else if (frac_taken < 2)
            begin
                num_mag = shift_in_digit(num_mag, 4'(c - CH_ZERO));
                frac_taken++;
            end
        end
        else if (is_digit)
        begin
            num_mag    = shift_in_digit(num_mag, 4'(c - CH_ZERO));
            line_phase = int_ph;
        end
        else if (with_frac && c == CH_DOT)
        begin
            line_phase = PH_SET_FRAC;
        end
        else if (line_phase == lead_ph &&
                 (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF))
        begin
            // leading blank, skipped
        end
        else if (line_phase == lead_ph && (c == CH_PLUS || c == CH_MINUS))
        begin
            num_neg    = (c == CH_MINUS);
            line_phase = int_ph;
        end
        else
        begin
            num_done = 1'b1;
        end
    endtask

    task automatic track_byte(input logic [7:0] c);
        int unsigned pos;
        logic [33:0] mag;
        cmd_t        hit;
        bit          emit;
        if (c == CH_CR)
            return;
        if (c == CH_LF)
        begin
            emit = 1'b0;
            hit  = '0;
            if (line_len > 0)
            begin
                case (line_phase)
                    PH_EN_OK:
                    begin
                        emit         = 1'b1;
                        hit.cmd_kind = KIND_ENABLE;
                    end
                    PH_DIS_OK:
                    begin
                        emit         = 1'b1;
                        hit.cmd_kind = KIND_DISABLE;
                    end
                    PH_SET_LEAD, PH_SET_INT, PH_SET_FRAC:
                    begin
                        // scale to hundredths for the fraction digits not seen
                        mag = num_mag;
                        for (int f = frac_taken; f < 2; f++)
                            mag = shift_in_digit(mag, 4'd0);
                        emit               = 1'b1;
                        hit.cmd_kind       = KIND_SETPOINT;
                        hit.pitch_centideg = signed_value(num_neg, mag);
                    end
                    PH_TURN_LEAD, PH_TURN_INT:
                    begin
                        emit             = 1'b1;
                        hit.cmd_kind     = KIND_TURN;
                        hit.turn_rate_hz = signed_value(num_neg, num_mag);
                    end
                    default: ;
                endcase
            end
            if (emit)
                expected_cmds.push_back(hit);
            clear_line_state();
            return;
        end
        // a character beyond the line limit is dropped and the line restarts
        if (line_len >= LINE_LIMIT)
        begin
            clear_line_state();
            return;
        end
        pos = line_len;
        line_len++;
        if (num_done)
            return;
        if (c == CH_NUL)
        begin
            num_done = 1'b1;
            return;
        end
        case (line_phase)
            PH_START:
            begin
                if (c == CH_E)
                    line_phase = PH_E;
                else if (c == CH_D)
                    line_phase = PH_D;
                else if (c == CH_S)
                    line_phase = PH_S;
                else if (c == CH_T)
                    line_phase = PH_T;
                else
                    line_phase = PH_REJECT;
            end
            PH_S:
            begin
                if (c == CH_T)
                    line_phase = PH_STOP;
                else if (c == CH_E)
                    line_phase = PH_SETP;
                else
                    line_phase = PH_REJECT;
            end
            PH_E, PH_D, PH_STOP, PH_SETP, PH_T:
                take_keyword_char(c, pos);
            PH_SET_LEAD, PH_SET_INT, PH_SET_FRAC:
                take_number_char(c, 1'b1);
            PH_TURN_LEAD, PH_TURN_INT:
                take_number_char(c, 1'b0);
            default:
                line_phase = PH_REJECT;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    logic [7:0] byte_queue[$];
    logic [7:0] line_buf[$];

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            byte_queue.push_back(s[i]);
    endtask

    task automatic queue_line(input string s);
        queue_text(s);
        byte_queue.push_back(CH_LF);
    endtask

    task automatic buf_word(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    // blanks, sign, integer digits, optional fraction, optional stray char
    task automatic buf_number(input bit with_frac);
        logic [7:0] blanks[4];
        int         n;
        blanks = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};
        repeat ($urandom_range(0, 2))
            line_buf.push_back(blanks[$urandom_range(0, 3)]);
        case ($urandom_range(0, 3))
            1: line_buf.push_back(CH_PLUS);
            2, 3: line_buf.push_back(CH_MINUS);
            default: ;
        endcase
        // mostly short numbers, now and then long enough to saturate
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 5);
        repeat (n)
            line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        if (with_frac && $urandom_range(0, 1) == 1)
        begin
            line_buf.push_back(CH_DOT);
            repeat ($urandom_range(0, 4))
                line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 5) == 0)
            line_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic queue_random_line();
        int    pick;
        int    cut;
        string word;
        line_buf.delete();
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            buf_word("ENABLE");
        end
        else if (pick < 17)
        begin
            buf_word("DISABLE");
        end
        else if (pick < 24)
        begin
            buf_word("STOP");
        end
        else if (pick < 52)
        begin
            buf_word("SETPOINT ");
            buf_number(1'b1);
        end
        else if (pick < 76)
        begin
            buf_word("TURN ");
            buf_number(1'b0);
        end
        else if (pick < 84)
        begin
            // keyword with one character hit by a random byte
            buf_word(keywords[$urandom_range(0, 4)]);
            line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 1)
                buf_number(1'b1);
        end
        else if (pick < 92)
        begin
            repeat ($urandom_range(0, 10))
                line_buf.push_back(8'($urandom_range(0, 255)));
        end
        else if (pick < 96)
        begin
            // around the line limit, sometimes spilling over it
            repeat ($urandom_range(LINE_LIMIT - 4, LINE_LIMIT + 12))
                line_buf.push_back(8'($urandom_range(33, 126)));
        end
        else
        begin
            // cut-off keyword
            word = keywords[$urandom_range(0, 4)];
            cut  = $urandom_range(1, word.len() - 1);
            buf_word(word.substr(0, cut - 1));
        end
        if (pick < 24 && $urandom_range(0, 7) == 0)
            line_buf.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 7) == 0)
            line_buf.insert($urandom_range(0, line_buf.size()), CH_CR);
        if ($urandom_range(0, 3) == 0)
            line_buf.push_back(CH_CR);
        foreach (line_buf[i])
            byte_queue.push_back(line_buf[i]);
        byte_queue.push_back(CH_LF);
    endtask

    // ------------------------------------------------------------------
    // Byte driver: offers queued bytes, idles in random bursts and feeds
    // every accepted item to the line tracker.
    // ------------------------------------------------------------------
    int bytes_taken = 0;
    int send_gap;
    bit idle_ok;        // idling allowed; off in every third window of 256 items and at the tail

    always @(posedge clk or negedge rst_n)
    begin : byte_driver
        bit taken;
        if (!rst_n)
        begin
            byte_ch.valid   <= 1'b0;
            byte_ch.rx_byte <= '0;
            send_gap        <= 0;
            idle_ok         <= 1'b0;
        end
        else
        begin
            taken = byte_ch.valid && byte_ch.ready;
            if (taken)
            begin
                track_byte(byte_ch.rx_byte);
                bytes_taken <= bytes_taken + 1;
            end
            idle_ok <= (byte_queue.size() > TAIL_BYTES) && ((bytes_taken / 256) % 3 != 2);
            if (byte_ch.valid && !taken)
            begin
                // item still on offer, hold it
            end
            else if (send_gap > 0)
            begin
                send_gap      <= send_gap - 1;
                byte_ch.valid <= 1'b0;
            end
            else if (idle_ok && $urandom_range(0, 9) == 0)
            begin
                send_gap      <= $urandom_range(0, 15);
                byte_ch.valid <= 1'b0;
            end
            else if (byte_queue.size() != 0)
            begin
                byte_ch.valid   <= 1'b1;
                byte_ch.rx_byte <= byte_queue.pop_front();
            end
            else
            begin
                byte_ch.valid <= 1'b0;
            end
        end
    end

    // One long output hold-off partway through: the output register fills,
    // the matcher stalls and the input backs up while bytes keep coming.
    int hold_left;
    bit hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && bytes_taken >= HOLD_AFTER)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Command monitor: checks each accepted command against the oldest
    // expected one and drives ready with random stall bursts.
    // ------------------------------------------------------------------
    int recv_gap;
    int error_count = 0;
    int kind_seen[4] = '{0, 0, 0, 0};

    always @(posedge clk or negedge rst_n)
    begin : cmd_monitor
        cmd_t want;
        if (!rst_n)
        begin
            cmd_ch.ready <= 1'b0;
            recv_gap     <= 0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                if (expected_cmds.size() == 0)
                begin
                    $error("unexpected command: kind %0d pitch %0d turn %0d",
                           cmd_ch.cmd_kind, cmd_ch.pitch_centideg, cmd_ch.turn_rate_hz);
                    error_count++;
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    kind_seen[want.cmd_kind]++;
                    if (cmd_ch.cmd_kind !== want.cmd_kind)
                    begin
                        $error("cmd_kind mismatch: expected %0d, got %0d",
                               want.cmd_kind, cmd_ch.cmd_kind);
                        error_count++;
                    end
                    if (cmd_ch.pitch_centideg !== want.pitch_centideg)
                    begin
                        $error("pitch_centideg mismatch: expected %0d, got %0d",
                               want.pitch_centideg, cmd_ch.pitch_centideg);
                        error_count++;
                    end
                    if (cmd_ch.turn_rate_hz !== want.turn_rate_hz)
                    begin
                        $error("turn_rate_hz mismatch: expected %0d, got %0d",
                               want.turn_rate_hz, cmd_ch.turn_rate_hz);
                        error_count++;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap     <= recv_gap - 1;
                cmd_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                cmd_ch.ready <= 1'b0;
            end
            else if (idle_ok && $urandom_range(0, 7) == 0)
            begin
                recv_gap     <= $urandom_range(0, 15);
                cmd_ch.ready <= 1'b0;
            end
            else
            begin
                cmd_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------
    int cycle_count = 0;

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_text_command_line_parser_top failed");
        $finish;
    end

    initial
    begin : stimulus
        rst_n           = 1'b0;
        byte_ch.valid   = 1'b0;
        byte_ch.rx_byte = '0;
        cmd_ch.ready    = 1'b0;
        clear_line_state();

        // Directed lines: each command, number edge cases, saturation both
        // ways, empty and unrecognized lines, zero byte, line length limit.
        queue_line("ENABLE");
        queue_text("DISABLE");
        byte_queue.push_back(CH_CR);
        byte_queue.push_back(CH_LF);
        queue_line("STOP");
        queue_line("SETPOINT 12.345");          // third fraction digit truncated
        queue_line("SETPOINT -0.5");
        queue_text("SETPOINT ");
        byte_queue.push_back(CH_TAB);
        byte_queue.push_back(CH_VT);
        byte_queue.push_back(CH_FF);
        byte_queue.push_back(CH_SPACE);
        queue_line("+7");                       // every blank kind, then a plus sign
        queue_line("SETPOINT 99999999999");     // positive saturation
        queue_line("SETPOINT -21474836.48");    // exactly the most negative value
        queue_line("TURN -2147483648");
        queue_line("TURN 2147483648");          // one past the positive limit
        queue_line("TURN ");                    // no digits gives zero
        queue_line("TURN 12abc");
        queue_line("SETPOINT 1e5");             // exponent not taken
        queue_line("SETPOINT 1.2.3");
        queue_line("TURN +-5");
        queue_line("SETPOINT -.");
        queue_line("SETPOINT");                 // keyword without its blank
        queue_line("ENABLEX");                  // extra text after a bare command
        byte_queue.push_back(CH_LF);            // empty line
        byte_queue.push_back(CH_CR);
        byte_queue.push_back(CH_LF);            // only a carriage return
        queue_text("EN");
        byte_queue.push_back(CH_NUL);
        queue_line("ABLE");                     // zero byte cuts the keyword short
        queue_text("ENABLE");
        byte_queue.push_back(CH_NUL);
        queue_line("xyz");                      // text after a zero byte is ignored
        for (int i = 0; i < LINE_LIMIT + 1; i++)
            queue_text("#");
        queue_line("STOP");                     // overflow restarts the line empty
        queue_text("TURN ");
        for (int i = 0; i < LINE_LIMIT - 6; i++)
            queue_text("0");
        queue_line("5");                        // line exactly at the limit

        while (byte_queue.size() < BYTE_TARGET)
            queue_random_line();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // drain: every byte taken, every command seen, then a short settle
        while (byte_queue.size() != 0 || byte_ch.valid)
            @(posedge clk);
        while (expected_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d bytes sent in %0d cycles, one %0d-cycle output hold-off",
                 bytes_taken, cycle_count, HOLD_CYCLES);
        $display("commands checked: %0d enable, %0d disable, %0d setpoint, %0d turn",
                 kind_seen[KIND_ENABLE], kind_seen[KIND_DISABLE],
                 kind_seen[KIND_SETPOINT], kind_seen[KIND_TURN]);
        if (error_count == 0)
            $display("tb_text_command_line_parser_top passed");
        else
            $display("tb_text_command_line_parser_top failed");
        $finish;
    end

endmodule
